// File: src/sphere_penetration_vector_top_assert.svh
// Assertion macros for the sphere penetration vector block.
`ifndef SPHERE_PENETRATION_VECTOR_TOP_ASSERT_SVH
`define SPHERE_PENETRATION_VECTOR_TOP_ASSERT_SVH

// stalled transfer keeps valid and payload
`define SPV_ASSERT_HOLD(lbl, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
        else $error("stalled transfer changed");

// same-cycle implication
`define SPV_ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication failed");

`endif

// File: src/spv_pkg.sv
// Shared types, widths and stage map of the sphere penetration vector pipeline.
package spv_pkg;

    localparam int IN_DATA_W  = 352;
    localparam int OUT_DATA_W = 96;

    localparam int T_STEPS = 32;
    localparam int R_STEPS = 36;
    localparam int Q_STEPS = 37;

    localparam int ST_A  = 0;
    localparam int ST_B  = 1;
    localparam int ST_C  = 2;
    localparam int ST_T0 = 3;
    localparam int ST_D  = ST_T0 + T_STEPS;
    localparam int ST_E  = ST_D + 1;
    localparam int ST_F  = ST_E + 1;
    localparam int ST_G  = ST_F + 1;
    localparam int ST_H  = ST_G + 1;
    localparam int ST_R0 = ST_H + 1;
    localparam int ST_S  = ST_R0 + R_STEPS;
    localparam int ST_M1 = ST_S + 1;
    localparam int ST_M2 = ST_M1 + 1;
    localparam int ST_Q0 = ST_M2 + 1;
    localparam int ST_OUT = ST_Q0 + Q_STEPS;
    localparam int NUM_STAGES = ST_OUT + 1;

    localparam logic [31:0] PUSH_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] PUSH_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        SEL_BASE = 2'd0,
        SEL_TIP  = 2'd1,
        SEL_FRAC = 2'd2
    } near_sel_t;

    typedef struct packed {
        logic              op;
        logic [2:0][31:0]  ego;
        logic [2:0][31:0]  base;
        logic [2:0][31:0]  tip;
        logic [30:0]       ego_r;
        logic [30:0]       oth_r;
        logic [31:0]       rsum;
        logic [2:0][32:0]  ab;
        logic [2:0][32:0]  ae;
        logic [2:0][65:0]  pab;
        logic [2:0][65:0]  pbb;
        logic [67:0]       num;
        logic [67:0]       den;
        near_sel_t         sel;
        logic [67:0]       tr;
        logic [31:0]       t;
        logic [2:0][64:0]  offp;
        logic [2:0][34:0]  near;
        logic [2:0]        dneg;
        logic [2:0][33:0]  dm;
        logic [2:0][67:0]  sq;
        logic [63:0]       rsq;
        logic              sep;
        logic [69:0]       srem;
        logic [35:0]       root;
        logic              sneg;
        logic [35:0]       smag;
        logic              zero;
        logic [2:0][51:0]  pl;
        logic [2:0][51:0]  ph;
        logic [2:0][72:0]  dn;
        logic [2:0][36:0]  dr;
        logic [2:0][36:0]  q;
        logic [2:0][31:0]  push;
    } pipe_t;

endpackage

// File: src/sphere_penetration_vector_top.sv
// Top level of the sphere penetration vector block: a fully pipelined datapath.
//
// One collision pair is taken per clock while the pipeline advances, and its
// push-out vector leaves the last of the spv_pkg::NUM_STAGES stages. The
// bit-serial steps are laid out as pipeline stages: 32 for the segment
// parameter division, 36 for the distance square root and 37 for the final
// scaling division. The whole pipeline advances whenever the output register is
// empty or is being taken, so s_tready follows m_tready while a result waits.
module sphere_penetration_vector_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // ego_x, ego_y, ego_z, ego_radius, base_x, base_y, base_z,
    // tip_x, tip_y, tip_z, other_radius, zero pad
    input  logic [spv_pkg::IN_DATA_W-1:0]  s_tdata,
    // opcode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // push_x, push_y, push_z
    output logic [spv_pkg::OUT_DATA_W-1:0] m_tdata,
    // separated
    output logic                           m_tuser
);

    localparam int N = spv_pkg::NUM_STAGES;

    spv_pkg::pipe_t stage_in  [N];
    spv_pkg::pipe_t pipe_next [N];
    spv_pkg::pipe_t pipe_reg  [N];
    logic [N-1:0]   vld_reg;
    logic           en;

    assign en       = !vld_reg[N-1] || m_tready;
    assign s_tready = en;

    always_comb
    begin
        stage_in[0]       = '0;
        stage_in[0].op    = s_tuser;
        stage_in[0].ego   = s_tdata[95:0];
        stage_in[0].ego_r = s_tdata[126:96];
        stage_in[0].base  = s_tdata[222:127];
        stage_in[0].tip   = s_tdata[318:223];
        stage_in[0].oth_r = s_tdata[349:319];
    end

    for (genvar k = 1; k < N; k++)
    begin : g_link
        assign stage_in[k] = pipe_reg[k-1];
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        if (k == spv_pkg::ST_A)
        begin : g_a
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                for (int i = 0; i < 3; i++)
                begin
                    pipe_next[k].ab[i] = $signed({stage_in[k].tip[i][31], stage_in[k].tip[i]})
                        - $signed({stage_in[k].base[i][31], stage_in[k].base[i]});
                    pipe_next[k].ae[i] = $signed({stage_in[k].ego[i][31], stage_in[k].ego[i]})
                        - $signed({stage_in[k].base[i][31], stage_in[k].base[i]});
                end
                pipe_next[k].rsum = {1'b0, stage_in[k].ego_r} + {1'b0, stage_in[k].oth_r};
            end
        end
        else if (k == spv_pkg::ST_B)
        begin : g_b
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                for (int i = 0; i < 3; i++)
                begin
                    pipe_next[k].pab[i] = $signed(stage_in[k].ae[i]) * $signed(stage_in[k].ab[i]);
                    pipe_next[k].pbb[i] = $signed(stage_in[k].ab[i]) * $signed(stage_in[k].ab[i]);
                end
            end
        end
        else if (k == spv_pkg::ST_C)
        begin : g_c
            logic signed [67:0] num_c;
            logic        [67:0] den_c;
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                num_c = $signed({{2{stage_in[k].pab[0][65]}}, stage_in[k].pab[0]})
                      + $signed({{2{stage_in[k].pab[1][65]}}, stage_in[k].pab[1]})
                      + $signed({{2{stage_in[k].pab[2][65]}}, stage_in[k].pab[2]});
                den_c = {2'b0, stage_in[k].pbb[0]} + {2'b0, stage_in[k].pbb[1]}
                      + {2'b0, stage_in[k].pbb[2]};
                pipe_next[k].num = num_c;
                pipe_next[k].den = den_c;
                pipe_next[k].tr  = num_c;
                pipe_next[k].t   = '0;
                if (!stage_in[k].op || num_c[67] || num_c == '0)
                    pipe_next[k].sel = spv_pkg::SEL_BASE;
                else if (num_c >= den_c)
                    pipe_next[k].sel = spv_pkg::SEL_TIP;
                else
                    pipe_next[k].sel = spv_pkg::SEL_FRAC;
            end
        end
        else if (k >= spv_pkg::ST_T0 && k < spv_pkg::ST_D)
        begin : g_t
            logic [68:0] rs;
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                rs = {stage_in[k].tr, 1'b0};
                if (rs >= {1'b0, stage_in[k].den})
                begin
                    pipe_next[k].tr = 68'(rs - {1'b0, stage_in[k].den});
                    pipe_next[k].t  = {stage_in[k].t[30:0], 1'b1};
                end
                else
                begin
                    pipe_next[k].tr = rs[67:0];
                    pipe_next[k].t  = {stage_in[k].t[30:0], 1'b0};
                end
            end
        end
        else if (k == spv_pkg::ST_D)
        begin : g_d
            logic [2:0][32:0] abm;
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                for (int i = 0; i < 3; i++)
                begin
                    abm[i] = stage_in[k].ab[i][32] ? 33'(-stage_in[k].ab[i]) : stage_in[k].ab[i];
                    pipe_next[k].offp[i] = {32'b0, abm[i]} * {33'b0, stage_in[k].t};
                end
            end
        end
        else if (k == spv_pkg::ST_E)
        begin : g_e
            logic [2:0][64:0] rnd;
            logic [2:0][34:0] off;
            logic [2:0][34:0] bse;
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                for (int i = 0; i < 3; i++)
                begin
                    rnd[i] = stage_in[k].offp[i] + 65'h0_8000_0000;
                    off[i] = {2'b0, rnd[i][64:32]};
                    bse[i] = {{3{stage_in[k].base[i][31]}}, stage_in[k].base[i]};
                    unique case (stage_in[k].sel)
                        spv_pkg::SEL_TIP:
                            pipe_next[k].near[i] = {{3{stage_in[k].tip[i][31]}},
                                                    stage_in[k].tip[i]};
                        spv_pkg::SEL_FRAC:
                            pipe_next[k].near[i] = stage_in[k].ab[i][32] ? bse[i] - off[i]
                                                                         : bse[i] + off[i];
                        default:
                            pipe_next[k].near[i] = bse[i];
                    endcase
                end
            end
        end
        else if (k == spv_pkg::ST_F)
        begin : g_f
            logic [2:0][35:0] dd;
            logic [2:0][35:0] dabs;
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                for (int i = 0; i < 3; i++)
                begin
                    dd[i] = {{4{stage_in[k].ego[i][31]}}, stage_in[k].ego[i]}
                          - {stage_in[k].near[i][34], stage_in[k].near[i]};
                    dabs[i] = dd[i][35] ? 36'(-dd[i]) : dd[i];
                    pipe_next[k].dneg[i] = dd[i][35];
                    pipe_next[k].dm[i]   = dabs[i][33:0];
                end
            end
        end
        else if (k == spv_pkg::ST_G)
        begin : g_g
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                for (int i = 0; i < 3; i++)
                    pipe_next[k].sq[i] = {34'b0, stage_in[k].dm[i]} * {34'b0, stage_in[k].dm[i]};
                pipe_next[k].rsq = {32'b0, stage_in[k].rsum} * {32'b0, stage_in[k].rsum};
            end
        end
        else if (k == spv_pkg::ST_H)
        begin : g_h
            logic [69:0] d2;
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                d2 = {2'b0, stage_in[k].sq[0]} + {2'b0, stage_in[k].sq[1]}
                   + {2'b0, stage_in[k].sq[2]};
                pipe_next[k].sep  = {6'b0, stage_in[k].rsq} < d2;
                pipe_next[k].srem = d2;
                pipe_next[k].root = '0;
            end
        end
        else if (k >= spv_pkg::ST_R0 && k < spv_pkg::ST_S)
        begin : g_r
            localparam int B = spv_pkg::R_STEPS - 1 - (k - spv_pkg::ST_R0);
            logic [71:0] trial;
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                trial = ({36'b0, stage_in[k].root} << (B + 1)) + (72'd1 << (2 * B));
                if ({2'b0, stage_in[k].srem} >= trial)
                begin
                    pipe_next[k].srem = 70'({2'b0, stage_in[k].srem} - trial);
                    pipe_next[k].root = stage_in[k].root | (36'd1 << B);
                end
            end
        end
        else if (k == spv_pkg::ST_S)
        begin : g_s
            logic [36:0] sc;
            logic [36:0] sabs;
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                sc   = {5'b0, stage_in[k].rsum} - {1'b0, stage_in[k].root};
                sabs = sc[36] ? 37'(-sc) : sc;
                pipe_next[k].sneg = sc[36];
                pipe_next[k].smag = sabs[35:0];
                pipe_next[k].zero = (stage_in[k].root == '0)
                                 || (!stage_in[k].op && stage_in[k].sep);
            end
        end
        else if (k == spv_pkg::ST_M1)
        begin : g_m1
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                for (int i = 0; i < 3; i++)
                begin
                    pipe_next[k].pl[i] = {18'b0, stage_in[k].dm[i]}
                                       * {34'b0, stage_in[k].smag[17:0]};
                    pipe_next[k].ph[i] = {18'b0, stage_in[k].dm[i]}
                                       * {34'b0, stage_in[k].smag[35:18]};
                end
            end
        end
        else if (k == spv_pkg::ST_M2)
        begin : g_m2
            logic [2:0][72:0] nn;
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                for (int i = 0; i < 3; i++)
                begin
                    nn[i] = {21'b0, stage_in[k].pl[i]} + ({21'b0, stage_in[k].ph[i]} << 18)
                          + {38'b0, stage_in[k].root[35:1]};
                    pipe_next[k].dn[i] = nn[i];
                    pipe_next[k].dr[i] = {1'b0, nn[i][72:37]};
                    pipe_next[k].q[i]  = '0;
                end
            end
        end
        else if (k >= spv_pkg::ST_Q0 && k < spv_pkg::ST_OUT)
        begin : g_q
            localparam int J = spv_pkg::Q_STEPS - 1 - (k - spv_pkg::ST_Q0);
            logic [2:0][37:0] r2;
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                for (int i = 0; i < 3; i++)
                begin
                    r2[i] = {stage_in[k].dr[i], stage_in[k].dn[i][J]};
                    if (r2[i] >= {2'b0, stage_in[k].root})
                    begin
                        pipe_next[k].dr[i] = 37'(r2[i] - {2'b0, stage_in[k].root});
                        pipe_next[k].q[i]  = {stage_in[k].q[i][35:0], 1'b1};
                    end
                    else
                    begin
                        pipe_next[k].dr[i] = r2[i][36:0];
                        pipe_next[k].q[i]  = {stage_in[k].q[i][35:0], 1'b0};
                    end
                end
            end
        end
        else
        begin : g_out
            logic [2:0] neg;
            always_comb
            begin
                pipe_next[k] = stage_in[k];
                for (int i = 0; i < 3; i++)
                begin
                    neg[i] = stage_in[k].dneg[i] ^ stage_in[k].sneg;
                    if (stage_in[k].zero)
                        pipe_next[k].push[i] = '0;
                    else if (neg[i])
                        pipe_next[k].push[i] =
                            (stage_in[k].q[i] > {5'b0, spv_pkg::PUSH_MIN}) ? spv_pkg::PUSH_MIN
                                                                     : 32'(-stage_in[k].q[i]);
                    else
                        pipe_next[k].push[i] =
                            (stage_in[k].q[i] > {5'b0, spv_pkg::PUSH_MAX}) ? spv_pkg::PUSH_MAX
                                                                     : stage_in[k].q[i][31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-2:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pipe_reg <= pipe_next;
    end

    assign m_tvalid = vld_reg[N-1];
    assign m_tdata  = pipe_reg[N-1].push;
    assign m_tuser  = pipe_reg[N-1].sep;

endmodule

// File: src/spv_checker.sv
// Port-level checker for the sphere penetration vector block, bound to the top level.
`include "sphere_penetration_vector_top_assert.svh"

module spv_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [spv_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    `SPV_ASSERT_HOLD(a_out_hold, m_tvalid, m_tready, {m_tdata, m_tuser})
    `SPV_ASSERT_IMPL(a_ready_when_empty, !m_tvalid, s_tready)
    `SPV_ASSERT_IMPL(a_stall_backpressure, m_tvalid && !m_tready, !s_tready)

endmodule

bind sphere_penetration_vector_top spv_checker u_spv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
